// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the checker file, ycc2rgb_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent, both in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ycc2rgb_pkg.sv =====
package ycc2rgb_pkg;

  // Tile and store limits
  localparam int MAX_ROW_WIDTH = 16;
  localparam int MAX_TILE_ROWS = 256;
  localparam int CHROMA_AW     = 12;
  localparam int CHROMA_DEPTH  = 1 << CHROMA_AW;

  // Queue between front and back
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  // Conversion coefficients, 8.8 fixed point
  localparam int COEF_CR_R  = 359;
  localparam int COEF_CB_G  = 88;
  localparam int COEF_CR_G  = 183;
  localparam int COEF_CB_B  = 454;
  localparam int CHROMA_OFS = 128;
  localparam int ROUND_HALF = 128;
  localparam int COMP_MAX   = 255;

  // Width of the signed sums before clamping
  localparam int SUM_W = 19;

  // Request codes
  typedef enum logic [1:0] {
    REQ_CB_WR = 2'd0,
    REQ_CR_WR = 2'd1,
    REQ_LUMA  = 2'd2
  } req_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_MCU_WIDTH  = 3'd0,
    CFG_MCU_HEIGHT = 3'd1,
    CFG_MCUS_TILE  = 3'd2,
    CFG_CB_SHIFT_X = 3'd3,
    CFG_CB_SHIFT_Y = 3'd4,
    CFG_CR_SHIFT_X = 3'd5,
    CFG_CR_SHIFT_Y = 3'd6
  } cfg_idx_e;

  // One classified item travelling from front to back
  typedef struct packed {
    req_e                  kind;
    logic [7:0]            sample;
    logic [CHROMA_AW-1:0]  cb_addr;
    logic [CHROMA_AW-1:0]  cr_addr;
    logic                  last;
  } qentry_t;

endpackage

// ===== rtl/core/ycbcr_upsample_to_rgb_unit.sv =====
// YCbCr to RGB conversion of one tile of MCUs, nearest-neighbor chroma upsampling.
// Load the Cb and Cr planes with chroma write commands, then issue luma pixels in raster
// order; each luma command yields one RGB result on valid_o after the command queue and
// the registered back-end stages, and chroma writes yield none. One command is taken every
// cycle: the back end drains the two-entry command queue one entry per cycle through a
// single write port and a single registered read port on each chroma plane, so busy stays
// low in normal use. Results come out as one-cycle strobes and cannot be stalled. The chroma
// planes are not cleared at reset; read only entries that were written. Write configuration
// only while no results are pending.
module ycbcr_upsample_to_rgb_unit import ycc2rgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command transfer
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [7:0]           sample_i,
  input  logic [CHROMA_AW-1:0] chroma_index_i,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i,
  // result transfer
  output logic                 valid_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 last_of_tile_o
);

  logic    push, full, q_valid, pop;
  qentry_t push_entry, pop_entry;

  assign busy = full;

  // Command intake and position tracking
  ycc2rgb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .sample_i       (sample_i),
    .chroma_index_i (chroma_index_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // Decoupling queue
  ycc2rgb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_data_o  (pop_entry)
  );

  // Chroma stores and color math
  ycc2rgb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .last_of_tile_o (last_of_tile_o)
  );

endmodule

// ===== rtl/core/ycc2rgb_front.sv =====
module ycc2rgb_front import ycc2rgb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command side
  input  logic                 start,
  input  logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [7:0]           sample_i,
  input  logic [CHROMA_AW-1:0] chroma_index_i,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i,
  // to queue
  output logic                 push_o,
  output qentry_t              entry_o
);

  logic [4:0] mcu_width_q, mcu_height_q, mcus_tile_q;
  logic [1:0] cb_sx_q, cb_sy_q, cr_sx_q, cr_sy_q;
  logic [3:0] col_q, col_d;
  logic [7:0] row_q, row_d;

  logic       accept;
  logic [4:0] width_eff;
  logic [9:0] rows_raw;
  logic [8:0] rows_eff;
  logic [3:0] last_col, col_eff;
  logic [7:0] last_row, row_eff;
  logic       at_last_col, at_last_row;

  // Chroma address of the nearest sample: (row >> sy) * (width >> sx) + (col >> sx)
  function automatic logic [CHROMA_AW-1:0] chroma_addr(
    input logic [7:0] row, input logic [3:0] col, input logic [4:0] width,
    input logic [1:0] sx, input logic [1:0] sy);
    logic [4:0]  stride;
    logic [12:0] prod;
    logic [12:0] sum;
    stride = width >> sx;
    prod   = 13'(row >> sy) * 13'(stride);
    sum    = prod + 13'(col >> sx);
    return sum[CHROMA_AW-1:0];
  endfunction

  assign accept = start && !busy;

  // Tile size, saturated to the supported range
  always_comb begin
    if (mcu_width_q == 5'd0) begin
      width_eff = 5'd1;
    end else if (mcu_width_q > 5'(MAX_ROW_WIDTH)) begin
      width_eff = 5'(MAX_ROW_WIDTH);
    end else begin
      width_eff = mcu_width_q;
    end
    rows_raw = 10'(mcu_height_q) * 10'(mcus_tile_q);
    if (rows_raw == 10'd0) begin
      rows_eff = 9'd1;
    end else if (rows_raw > 10'(MAX_TILE_ROWS)) begin
      rows_eff = 9'(MAX_TILE_ROWS);
    end else begin
      rows_eff = rows_raw[8:0];
    end
    last_col = 4'(width_eff - 5'd1);
    last_row = 8'(rows_eff - 9'd1);
  end

  // Position, pulled back inside the tile if the size shrank
  assign col_eff     = (col_q > last_col) ? last_col : col_q;
  assign row_eff     = (row_q > last_row) ? last_row : row_q;
  assign at_last_col = (col_eff == last_col);
  assign at_last_row = (row_eff == last_row);

  // Classify the command into a queue entry
  always_comb begin
    push_o        = 1'b0;
    entry_o.kind  = REQ_LUMA;
    entry_o.sample  = sample_i;
    entry_o.cb_addr = chroma_index_i;
    entry_o.cr_addr = chroma_index_i;
    entry_o.last    = 1'b0;
    col_d = col_q;
    row_d = row_q;
    case (req_type_i)
      REQ_CB_WR: begin
        push_o       = accept;
        entry_o.kind = REQ_CB_WR;
      end
      REQ_CR_WR: begin
        push_o       = accept;
        entry_o.kind = REQ_CR_WR;
      end
      REQ_LUMA: begin
        push_o          = accept;
        entry_o.kind    = REQ_LUMA;
        entry_o.cb_addr = chroma_addr(row_eff, col_eff, width_eff, cb_sx_q, cb_sy_q);
        entry_o.cr_addr = chroma_addr(row_eff, col_eff, width_eff, cr_sx_q, cr_sy_q);
        entry_o.last    = at_last_col && at_last_row;
        if (accept) begin
          if (at_last_col) begin
            col_d = 4'd0;
            row_d = at_last_row ? 8'd0 : row_eff + 8'd1;
          end else begin
            col_d = col_eff + 4'd1;
            row_d = row_eff;
          end
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  // Position counters and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      mcu_width_q  <= 5'd8;
      mcu_height_q <= 5'd8;
      mcus_tile_q  <= 5'd1;
      cb_sx_q      <= '0;
      cb_sy_q      <= '0;
      cr_sx_q      <= '0;
      cr_sy_q      <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MCU_WIDTH:  mcu_width_q  <= cfg_data_i;
          CFG_MCU_HEIGHT: mcu_height_q <= cfg_data_i;
          CFG_MCUS_TILE:  mcus_tile_q  <= cfg_data_i;
          CFG_CB_SHIFT_X: cb_sx_q      <= cfg_data_i[1:0];
          CFG_CB_SHIFT_Y: cb_sy_q      <= cfg_data_i[1:0];
          CFG_CR_SHIFT_X: cr_sx_q      <= cfg_data_i[1:0];
          CFG_CR_SHIFT_Y: cr_sy_q      <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/ycc2rgb_queue.sv =====
module ycc2rgb_queue import ycc2rgb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  qentry_t push_data_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    valid_o,
  output qentry_t pop_data_o
);

  qentry_t             slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_AW:0]   count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slots_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/ycc2rgb_back.sv =====
module ycc2rgb_back import ycc2rgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  qentry_t    entry_i,
  output logic       pop_o,
  output logic       valid_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       last_of_tile_o
);

  logic [7:0] cb_mem [CHROMA_DEPTH];
  logic [7:0] cr_mem [CHROMA_DEPTH];

  // stage 1: chroma read data
  logic       v1_q, last1_q;
  logic [7:0] y1_q, cb1_q, cr1_q;
  // stage 2: products
  logic              v2_q, last2_q;
  logic [7:0]        y2_q;
  logic signed [SUM_W-1:0] pr_q, pg_q, pb_q;
  // stage 3: outputs
  logic       v3_q, last3_q;
  logic [7:0] r3_q, g3_q, b3_q;

  logic              is_luma;
  logic signed [8:0] cb_c, cr_c;
  logic signed [SUM_W-1:0] y_full, sr, sg, sb;

  // The back never stalls: take one entry every cycle
  assign pop_o   = valid_i;
  assign is_luma = valid_i && (entry_i.kind == REQ_LUMA);

  // Cb plane: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (valid_i && entry_i.kind == REQ_CB_WR) begin
      cb_mem[entry_i.cb_addr] <= entry_i.sample;
    end
    cb1_q <= cb_mem[entry_i.cb_addr];
  end

  // Cr plane
  always_ff @(posedge clk_i) begin
    if (valid_i && entry_i.kind == REQ_CR_WR) begin
      cr_mem[entry_i.cr_addr] <= entry_i.sample;
    end
    cr1_q <= cr_mem[entry_i.cr_addr];
  end

  // Centered chroma
  assign cb_c = $signed({1'b0, cb1_q}) - 9'sd128;
  assign cr_c = $signed({1'b0, cr1_q}) - 9'sd128;

  // Sums with rounding
  assign y_full = $signed({3'b000, y2_q, 8'h00}) + SUM_W'(ROUND_HALF);
  assign sr = y_full + pr_q;
  assign sg = y_full + pg_q;
  assign sb = y_full + pb_q;

  // Clamp a rounded 8.8 value to one component
  function automatic logic [7:0] clamp8(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-9:0] ip;
    ip = v[SUM_W-1:8];
    if (v < 0) begin
      return 8'd0;
    end else if (ip > (SUM_W-8)'(COMP_MAX)) begin
      return 8'(COMP_MAX);
    end else begin
      return ip[7:0];
    end
  endfunction

  // Data pipeline
  always_ff @(posedge clk_i) begin
    y1_q    <= entry_i.sample;
    last1_q <= entry_i.last;
    y2_q    <= y1_q;
    last2_q <= last1_q;
    pr_q    <= SUM_W'(cr_c * 12'sd359);
    pg_q    <= SUM_W'(-(cb_c * 12'sd88) - (cr_c * 12'sd183));
    pb_q    <= SUM_W'(cb_c * 12'sd454);
    r3_q    <= clamp8(sr);
    g3_q    <= clamp8(sg);
    b3_q    <= clamp8(sb);
  end

  // Valid bits through the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      last3_q <= 1'b0;
    end else begin
      v1_q    <= is_luma;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      last3_q <= v2_q && last2_q;
    end
  end

  assign valid_o        = v3_q;
  assign red_o          = r3_q;
  assign green_o        = g3_q;
  assign blue_o         = b3_q;
  assign last_of_tile_o = last3_q;

endmodule

// ===== rtl/core/ycc2rgb_checker.sv =====
`include "assert_macros.svh"

module ycc2rgb_checker import ycc2rgb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] req_type_i,
  input logic       valid_o,
  input logic       last_of_tile_o
);

  logic luma_xfer;

  assign luma_xfer = start && !busy && (req_type_i == REQ_LUMA);

  // Every accepted pixel gives a result once it has passed the queue and the back-end pipeline
  `ASSERT_ALWAYS(a_pixel_gives_result, luma_xfer |-> ##4 valid_o, "pixel result missing")

  // No result without a matching accepted pixel
  `ASSERT_ALWAYS(a_result_has_pixel, valid_o |-> $past(luma_xfer, 4), "spurious result")

  // The tile end flag only rides on a result
  `ASSERT_IMPLIES(a_last_needs_valid, last_of_tile_o, valid_o, "tile end flag without result")

endmodule

bind ycbcr_upsample_to_rgb_unit ycc2rgb_checker u_checker (.*);
